// ===== src/pnc_pkg.sv =====
// Shared types and constants of the palette nearest-color search.
// No dependencies; every other file of the block but pnc_ram imports this package.
`default_nettype none
package pnc_pkg;

  localparam int PALETTE_SIZE = 256;
  localparam int IDX_W        = $clog2(PALETTE_SIZE);
  localparam int COLOR_W      = 24;
  localparam int CHAN_W       = 8;
  localparam int CELL_W       = 3;
  localparam int SQ_W         = 2 * CHAN_W;
  localparam int DIST_W       = 18;
  localparam int KEY_W        = 3 * CELL_W + 8;

  // Larger than any real squared distance, so the first candidate always wins.
  localparam logic [DIST_W-1:0] DIST_START = DIST_W'(3 * 256 * 256);

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_FINISH
  } pnc_state_t;

  // Palette entry as it leaves the memory, tagged with its index.
  typedef struct packed {
    logic               vld;
    logic               last;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] color;
  } pnc_samp_t;

  // Per-channel squared differences and neighborhood information.
  typedef struct packed {
    logic               vld;
    logic               last;
    logic               near;
    logic [IDX_W-1:0]   idx;
    logic [KEY_W-1:0]   key;
    logic [SQ_W-1:0]    sq_r;
    logic [SQ_W-1:0]    sq_g;
    logic [SQ_W-1:0]    sq_b;
  } pnc_term_t;

  // Running minima of one query.
  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   idx_n;
    logic [DIST_W-1:0]  dist_n;
    logic [IDX_W-1:0]   idx_f;
    logic [DIST_W-1:0]  dist_f;
  } pnc_best_t;

endpackage
`default_nettype wire

// ===== src/pnc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none
module pnc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/pnc_dist.sv =====
// Distance stage: per-channel squared differences and the neighborhood test
// for one palette entry per cycle. Depends on pnc_pkg.
`default_nettype none
module pnc_dist (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pnc_pkg::pnc_samp_t    samp,
  input  wire logic [7:0]            q_red,
  input  wire logic [7:0]            q_green,
  input  wire logic [7:0]            q_blue,
  output      pnc_pkg::pnc_term_t    term
);
  import pnc_pkg::*;

  logic [CHAN_W-1:0] c_r, c_g, c_b;
  logic [CHAN_W-1:0] ad_r, ad_g, ad_b;
  logic [CELL_W-1:0] cl_r, cl_g, cl_b;
  logic              nr_r, nr_g, nr_b;
  pnc_term_t         term_r, term_nxt;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    abs_diff = (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic cell_near(input logic [CELL_W-1:0] a,
                                     input logic [CELL_W-1:0] b);
    logic [CELL_W:0] ea, eb;
    ea = {1'b0, a};
    eb = {1'b0, b};
    cell_near = (ea == eb) || (ea == eb + 1'b1) || (eb == ea + 1'b1);
  endfunction

  always_comb begin
    c_r  = samp.color[23:16];
    c_g  = samp.color[15:8];
    c_b  = samp.color[7:0];
    cl_r = c_r[7:5];
    cl_g = c_g[7:5];
    cl_b = c_b[7:5];
    ad_r = abs_diff(q_red, c_r);
    ad_g = abs_diff(q_green, c_g);
    ad_b = abs_diff(q_blue, c_b);
    nr_r = cell_near(cl_r, q_red[7:5]);
    nr_g = cell_near(cl_g, q_green[7:5]);
    nr_b = cell_near(cl_b, q_blue[7:5]);

    term_nxt.vld  = samp.vld;
    term_nxt.last = samp.last;
    term_nxt.near = nr_r && nr_g && nr_b;
    term_nxt.idx  = samp.idx;
    term_nxt.key  = {cl_r, cl_g, cl_b, 8'(samp.idx)};
    term_nxt.sq_r = ad_r * ad_r;
    term_nxt.sq_g = ad_g * ad_g;
    term_nxt.sq_b = ad_b * ad_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r.vld  <= 1'b0;
      term_r.last <= 1'b0;
    end else begin
      term_r.vld  <= term_nxt.vld;
      term_r.last <= term_nxt.last;
    end
    term_r.near <= term_nxt.near;
    term_r.idx  <= term_nxt.idx;
    term_r.key  <= term_nxt.key;
    term_r.sq_r <= term_nxt.sq_r;
    term_r.sq_g <= term_nxt.sq_g;
    term_r.sq_b <= term_nxt.sq_b;
  end

  assign term = term_r;

endmodule
`default_nettype wire

// ===== src/pnc_track.sv =====
// Minimum tracker: sums the squared differences and keeps the neighborhood
// and full-search minima of one query side by side. Depends on pnc_pkg.
`default_nettype none
module pnc_track (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire pnc_pkg::pnc_term_t  term,
  output      pnc_pkg::pnc_best_t  best,
  output      logic                done
);
  import pnc_pkg::*;

  logic [DIST_W-1:0] dist_sum;
  logic [KEY_W-1:0]  key_r, key_nxt;
  pnc_best_t         best_r, best_nxt;
  logic              done_r;
  logic              take_n, take_f;

  always_comb begin
    dist_sum = DIST_W'(term.sq_r) + DIST_W'(term.sq_g) + DIST_W'(term.sq_b);
    // Ties inside the neighborhood go to the smaller (cell, index) key.
    take_n = term.vld && term.near &&
             ((dist_sum < best_r.dist_n) ||
              ((dist_sum == best_r.dist_n) && best_r.found && (term.key < key_r)));
    // The full search leaves out the last palette slot.
    take_f = term.vld && (term.idx != IDX_W'(PALETTE_SIZE - 1)) &&
             (dist_sum < best_r.dist_f);

    best_nxt = best_r;
    key_nxt  = key_r;
    if (start) begin
      best_nxt.found  = 1'b0;
      best_nxt.idx_n  = '0;
      best_nxt.dist_n = DIST_START;
      best_nxt.idx_f  = '0;
      best_nxt.dist_f = DIST_START;
      key_nxt         = '0;
    end else begin
      if (take_n) begin
        best_nxt.found  = 1'b1;
        best_nxt.idx_n  = term.idx;
        best_nxt.dist_n = dist_sum;
        key_nxt         = term.key;
      end
      if (take_f) begin
        best_nxt.idx_f  = term.idx;
        best_nxt.dist_f = dist_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r.found <= 1'b0;
      done_r       <= 1'b0;
    end else begin
      best_r.found <= best_nxt.found;
      done_r       <= term.vld && term.last;
    end
    best_r.idx_n  <= best_nxt.idx_n;
    best_r.dist_n <= best_nxt.dist_n;
    best_r.idx_f  <= best_nxt.idx_f;
    best_r.dist_f <= best_nxt.dist_f;
    key_r         <= key_nxt;
  end

  assign best = best_r;
  assign done = done_r;

endmodule
`default_nettype wire

// ===== src/palette_nearest_color.sv =====
// Top level of the palette nearest-color search: control sequencer, palette
// memory with per-entry valid bits, and the result register.
// Depends on pnc_pkg, pnc_ram, pnc_dist and pnc_track.
//
//   Channel  Ports                                   Direction  Word
//   in       in_valid/in_ready, in_func, in_entry_*, input      write or query
//            in_query_*
//   out      out_valid/out_ready, out_color_index,   output     one per query
//            out_best_distance, out_used_fallback
//
// A write goes into memory on the edge that accepts it. A query reads all
// 256 palette entries through the memory's single read port, one per cycle,
// then drains the three-stage distance pipeline and loads the result. Reset
// clears the valid bits at once, so every entry reads as zero until it is
// written. A query result that finds the output register still full waits
// until it is taken; no new word is accepted meanwhile.
`default_nettype none
module palette_nearest_color (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic        in_func,
  input  wire logic [7:0]  in_entry_index,
  input  wire logic [23:0] in_entry_color,
  input  wire logic [7:0]  in_query_red,
  input  wire logic [7:0]  in_query_green,
  input  wire logic [7:0]  in_query_blue,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [7:0]  out_color_index,
  output      logic [17:0] out_best_distance,
  output      logic        out_used_fallback
);
  import pnc_pkg::*;

  pnc_state_t         state_r, state_nxt;
  logic [IDX_W-1:0]   addr_r, addr_nxt;
  logic               vld_bits_r [PALETTE_SIZE];
  logic               ent_vld_r;
  logic               s0_vld_r, s0_last_r;
  logic [IDX_W-1:0]   s0_idx_r;
  logic [7:0]         q_red_r, q_green_r, q_blue_r;
  logic [COLOR_W-1:0] ram_rdata;
  logic               wr_en, start, issue, load_out, last_addr;
  pnc_samp_t          samp;
  pnc_term_t          term;
  pnc_best_t          best;
  logic               done;
  logic               out_valid_r;
  logic [7:0]         out_idx_r;
  logic [DIST_W-1:0]  out_dist_r;
  logic               out_fb_r;

  assign last_addr = (addr_r == IDX_W'(PALETTE_SIZE - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_func == FUNC_QUERY)) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (last_addr) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_SEARCH: issue    = 1'b1;
      ST_DRAIN:  ;
      ST_FINISH: load_out = !out_valid_r || out_ready;
      default:   ;
    endcase
  end

  assign start = in_valid && in_ready && (in_func == FUNC_QUERY);
  assign wr_en = in_valid && in_ready && (in_func == FUNC_WRITE) &&
                 (32'(in_entry_index) < PALETTE_SIZE);

  always_comb begin
    addr_nxt = addr_r;
    if (start) begin
      addr_nxt = '0;
    end else if (issue) begin
      addr_nxt = addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      addr_r    <= '0;
      s0_vld_r  <= 1'b0;
      s0_last_r <= 1'b0;
      for (int i = 0; i < PALETTE_SIZE; i++) begin
        vld_bits_r[i] <= 1'b0;
      end
    end else begin
      state_r   <= state_nxt;
      addr_r    <= addr_nxt;
      s0_vld_r  <= issue;
      s0_last_r <= issue && last_addr;
      if (wr_en) begin
        vld_bits_r[IDX_W'(in_entry_index)] <= 1'b1;
      end
    end
    s0_idx_r  <= addr_r;
    ent_vld_r <= vld_bits_r[addr_r];
    if (start) begin
      q_red_r   <= in_query_red;
      q_green_r <= in_query_green;
      q_blue_r  <= in_query_blue;
    end
  end

  pnc_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_SIZE)
  ) u_palette (
    .clk   (clk),
    .we    (wr_en),
    .waddr (IDX_W'(in_entry_index)),
    .wdata (in_entry_color),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  // An entry never written since reset reads as black.
  always_comb begin
    samp.vld   = s0_vld_r;
    samp.last  = s0_last_r;
    samp.idx   = s0_idx_r;
    samp.color = ent_vld_r ? ram_rdata : '0;
  end

  pnc_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .samp    (samp),
    .q_red   (q_red_r),
    .q_green (q_green_r),
    .q_blue  (q_blue_r),
    .term    (term)
  );

  pnc_track u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .term  (term),
    .best  (best),
    .done  (done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (load_out) begin
      out_fb_r   <= !best.found;
      out_idx_r  <= best.found ? 8'(best.idx_n) : 8'(best.idx_f);
      out_dist_r <= best.found ? best.dist_n : best.dist_f;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_color_index   = out_idx_r;
  assign out_best_distance = out_dist_r;
  assign out_used_fallback = out_fb_r;

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for palette_nearest_color: writes and queries,
// checked against a predictor.
// Depends on pnc_pkg and the palette_nearest_color RTL. It reads no files.
module tb_top;
  import pnc_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE_CYCLES = 300;

  typedef struct packed {
    logic [7:0]  color_index;
    logic [17:0] best_distance;
    logic        used_fallback;
  } nearest_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_func = FUNC_WRITE;
  logic [7:0]  in_entry_index = '0;
  logic [23:0] in_entry_color = '0;
  logic [7:0]  in_query_red = '0;
  logic [7:0]  in_query_green = '0;
  logic [7:0]  in_query_blue = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_color_index;
  logic [17:0] out_best_distance;
  logic        out_used_fallback;

  // Mirror of the palette contents and results still owed by the block.
  logic [23:0]     palette_mirror [PALETTE_SIZE];
  nearest_result_t pending_results [$];

  bit in_gaps_on = 1'b1;
  bit out_gaps_on = 1'b1;
  int stall_cnt = 0;
  int cycle_cnt = 0;
  int error_cnt = 0;
  int n_writes = 0;
  int n_queries = 0;
  int n_fallback = 0;
  int n_checked = 0;

  palette_nearest_color dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_entry_index    (in_entry_index),
    .in_entry_color    (in_entry_color),
    .in_query_red      (in_query_red),
    .in_query_green    (in_query_green),
    .in_query_blue     (in_query_blue),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_color_index   (out_color_index),
    .out_best_distance (out_best_distance),
    .out_used_fallback (out_used_fallback)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_cnt, pending_results.size());
      $display("palette_nearest_color: mismatch");
      $finish;
    end
  end

  function automatic bit cell_near(input logic [2:0] a, input logic [2:0] b);
    return (a > b) ? ((a - b) <= 3'd1) : ((b - a) <= 3'd1);
  endfunction

  function automatic int unsigned sq_distance(input logic [23:0] entry, input logic [7:0] red,
                                              input logic [7:0] green, input logic [7:0] blue);
    int dr, dg, db;
    dr = int'(red) - int'(entry[23:16]);
    dg = int'(green) - int'(entry[15:8]);
    db = int'(blue) - int'(entry[7:0]);
    return dr * dr + dg * dg + db * db;
  endfunction

  function automatic nearest_result_t nearest_color(input logic [7:0] red,
                                                    input logic [7:0] green,
                                                    input logic [7:0] blue);
    nearest_result_t res;
    logic [23:0]     entry;
    logic [16:0]     key;
    logic [16:0]     best_key;
    int unsigned     d;
    int unsigned     best_d;
    int              best_i;
    bit              found;
    best_d   = DIST_START;
    best_key = '0;
    best_i   = 0;
    found    = 1'b0;
    // Neighborhood pass: ties are broken by (cell, index) order.
    for (int k = 0; k < PALETTE_SIZE; k++) begin
      entry = palette_mirror[k];
      if (cell_near(entry[23:21], red[7:5]) && cell_near(entry[15:13], green[7:5]) &&
          cell_near(entry[7:5], blue[7:5])) begin
        key = {entry[23:21], entry[15:13], entry[7:5], k[7:0]};
        d   = sq_distance(entry, red, green, blue);
        if (d < best_d || (d == best_d && found && key < best_key)) begin
          best_d   = d;
          best_key = key;
          best_i   = k;
          found    = 1'b1;
        end
      end
    end
    // The full search skips the last entry and keeps the lowest index on a tie.
    if (!found) begin
      best_d = DIST_START;
      best_i = 0;
      for (int k = 0; k < PALETTE_SIZE - 1; k++) begin
        d = sq_distance(palette_mirror[k], red, green, blue);
        if (d < best_d) begin
          best_d = d;
          best_i = k;
        end
      end
    end
    res.color_index   = best_i[7:0];
    res.best_distance = best_d[17:0];
    res.used_fallback = !found;
    return res;
  endfunction

  // Result side: checks every accepted word and draws a stall after each one.
  always @(posedge clk) begin
    nearest_result_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("Result word with no query waiting: color_index %0d", out_color_index);
        error_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_color_index !== want.color_index) begin
          $error("color_index: expected %0d, got %0d", want.color_index, out_color_index);
          error_cnt++;
        end
        if (out_best_distance !== want.best_distance) begin
          $error("best_distance: expected %0d, got %0d", want.best_distance,
                 out_best_distance);
          error_cnt++;
        end
        if (out_used_fallback !== want.used_fallback) begin
          $error("used_fallback: expected %0d, got %0d", want.used_fallback,
                 out_used_fallback);
          error_cnt++;
        end
        n_checked++;
      end
      stall_cnt = out_gaps_on ? $urandom_range(0, 4) : 0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
    end
    out_ready <= (stall_cnt == 0);
  end

  // Sends one word. Every task returns just after a rising edge, and a valid that
  // stays high for the next word is never lowered in the same step.
  task automatic send_word(input logic func, input logic [7:0] idx, input logic [23:0] color,
                           input logic [7:0] red, input logic [7:0] green,
                           input logic [7:0] blue);
    int              gap;
    nearest_result_t res;
    gap = in_gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= func;
    in_entry_index <= idx;
    in_entry_color <= color;
    in_query_red   <= red;
    in_query_green <= green;
    in_query_blue  <= blue;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    if (func == FUNC_WRITE) begin
      if (int'(idx) < PALETTE_SIZE) palette_mirror[idx] = color;
      n_writes++;
    end else begin
      res = nearest_color(red, green, blue);
      pending_results = {pending_results, res};
      n_queries++;
      if (res.used_fallback) n_fallback++;
    end
  endtask

  task automatic write_entry(input logic [7:0] idx, input logic [23:0] color);
    send_word(FUNC_WRITE, idx, color, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic query_color(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue);
    send_word(FUNC_QUERY, 8'($urandom), 24'($urandom), red, green, blue);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling();
    in_gaps_on = ($urandom_range(0, 3) != 0);
    out_gaps_on <= ($urandom_range(0, 3) != 0);
  endtask

  function automatic logic [7:0] coarse_level();
    case ($urandom_range(0, 8))
      0:       return 8'h00;
      1:       return 8'h1F;
      2:       return 8'h20;
      3:       return 8'h21;
      4:       return 8'h3F;
      5:       return 8'h40;
      6:       return 8'h5F;
      7:       return 8'h60;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic logic [23:0] corner_color();
    return {8'($urandom_range(0, 8'h5F)), 8'($urandom_range(0, 8'h5F)),
            8'($urandom_range(0, 8'h5F))};
  endfunction

  // The palette is all zero after reset: near and far queries, extreme distances.
  task automatic test_empty_palette();
    query_color(8'h00, 8'h00, 8'h00);
    query_color(8'hFF, 8'hFF, 8'hFF);
    query_color(8'h3F, 8'h3F, 8'h3F);
    query_color(8'h40, 8'h00, 8'h00);
  endtask

  // The last entry is searched in the neighborhood but skipped by the full search.
  task automatic test_index_extremes();
    write_entry(8'hFF, 24'hFFFFFF);
    query_color(8'hFF, 8'hFF, 8'hFF);
    write_entry(8'hFF, 24'hA0A0A0);
    query_color(8'hFF, 8'hFF, 8'hFF);
    write_entry(8'h00, 24'hFFFFFF);
    query_color(8'hFF, 8'hFF, 8'hFF);
    write_entry(8'h00, 24'h000000);
    write_entry(8'hFF, 24'h000000);
  endtask

  // Equal distances: the lower cell wins over the lower index in the neighborhood,
  // and the full search keeps the lowest index.
  task automatic test_cell_ties();
    write_entry(8'd1, 24'h212020);
    write_entry(8'd2, 24'h1F2020);
    write_entry(8'd4, 24'h1F2020);
    query_color(8'h20, 8'h20, 8'h20);
    write_entry(8'd10, 24'h606060);
    write_entry(8'd11, 24'h606060);
    query_color(8'hFF, 8'h00, 8'h60);
  endtask

  task automatic test_random_traffic(input int n_items);
    for (int n = 0; n < n_items; n++) begin
      if (n % 64 == 0) set_idling();
      if ($urandom_range(0, 1) == 0) write_entry(8'($urandom), 24'($urandom));
      else query_color(8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // Colors and queries from a few levels near cell borders, so ties are common.
  task automatic test_clustered_ties(input int n_items);
    for (int n = 0; n < n_items; n++) begin
      if (n % 64 == 0) set_idling();
      if ($urandom_range(0, 9) < 4)
        write_entry(8'($urandom), {coarse_level(), coarse_level(), coarse_level()});
      else
        query_color(coarse_level(), coarse_level(), coarse_level());
    end
  endtask

  // Packs the whole palette into the dark corner, so most queries find an empty
  // neighborhood and take the full search.
  task automatic test_corner_fallback(input int n_items);
    for (int k = 0; k < PALETTE_SIZE; k++) begin
      if (k % 64 == 0) set_idling();
      write_entry(k[7:0], corner_color());
    end
    for (int n = 0; n < n_items; n++) begin
      if (n % 64 == 0) set_idling();
      case ($urandom_range(0, 7))
        0:       write_entry(8'($urandom), corner_color());
        1:       write_entry(8'hFF, 24'($urandom));
        default: query_color(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
    end
  endtask

  initial begin
    for (int k = 0; k < PALETTE_SIZE; k++) palette_mirror[k] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_palette();
    test_index_extremes();
    test_cell_ties();
    wait_for_results();
    test_random_traffic(800);
    wait_for_results();
    test_clustered_ties(500);
    wait_for_results();
    test_corner_fallback(450);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d palette writes and %0d queries; %0d results checked.",
             n_writes, n_queries, n_checked);
    $display("%0d queries found no neighbor and went through the full search.", n_fallback);
    if (error_cnt == 0) begin
      $display("palette_nearest_color: match");
    end else begin
      $display("palette_nearest_color: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/pnc_pkg.sv
src/pnc_ram.sv
src/pnc_dist.sv
src/pnc_track.sv
src/palette_nearest_color.sv
verif/tb_top.sv
